>>> hdl/ipu_pkg.sv
package ipu_pkg;

  // Low bits of the input number that are used, read as two's complement.
  localparam int NUMBER_WIDTH = 32;
  localparam int NUM_IN_W     = 32;
  localparam int MODE_W       = 3;
  localparam int VALUE_W      = 34;
  // Digit sum of at most ten decimal digits stays below 128.
  localparam int SUM_W        = 7;
  localparam int DIGIT_W      = 4;
  localparam int CNT_W        = $clog2(NUMBER_WIDTH);

  localparam int DEC_BASE      = 10;
  localparam int FIRST_DIVISOR = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PARITY = 3'd0,
    MODE_PRIME  = 3'd1,
    MODE_PAL    = 3'd2,
    MODE_SIGN   = 3'd3,
    MODE_REV    = 3'd4,
    MODE_SUM    = 3'd5
  } mode_e;

  localparam logic [1:0] SIGN_POS  = 2'd0;
  localparam logic [1:0] SIGN_NEG  = 2'd1;
  localparam logic [1:0] SIGN_ZERO = 2'd2;

  typedef struct packed {
    logic                    start;
    logic [NUMBER_WIDTH-1:0] dividend;
    logic [NUMBER_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic [NUMBER_WIDTH-1:0] quotient;
    logic [NUMBER_WIDTH-1:0] remainder;
  } div_rsp_t;

endpackage

>>> hdl/ipu_if.sv
interface ipu_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ipu_pkg::NUM_IN_W-1:0] number;
  logic [ipu_pkg::MODE_W-1:0]          mode;

  modport source (output valid, output number, output mode, input ready);
  modport sink   (input valid, input number, input mode, output ready);
endinterface

interface ipu_out_if;
  logic                        valid;
  logic                        ready;
  logic                        answer_bit;
  logic [1:0]                  sign_class;
  logic [ipu_pkg::VALUE_W-1:0] value_out;
  logic                        bad_mode;

  modport source (output valid, output answer_bit, output sign_class, output value_out,
                  output bad_mode, input ready);
  modport sink   (input valid, input answer_bit, input sign_class, input value_out,
                  input bad_mode, output ready);
endinterface

>>> hdl/ipu_div.sv
// Restoring divider, one quotient bit per cycle.
module ipu_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipu_pkg::div_req_t req_i,
  output ipu_pkg::div_rsp_t rsp_o
);
  localparam int NW = ipu_pkg::NUMBER_WIDTH;

  logic [NW-1:0]               rem_q, quo_q, den_q;
  logic [ipu_pkg::CNT_W-1:0]   cnt_q;
  logic                        busy_q, done_q;
  logic [NW:0]                 trial, diff;
  logic                        ge;

  assign trial = {rem_q, quo_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ipu_pkg::CNT_W'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[NW-1:0] : trial[NW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a running division");

endmodule

>>> hdl/integer_property_unit.sv
// Channel | dir | payload                                      | handshake
// in_i    | in  | number[31:0] signed, mode[2:0]               | valid/ready
// out_o   | out | answer_bit, sign_class[1:0], value_out[33:0], | valid/ready
//         |     | bad_mode                                     |
//
// Parity, sign and invalid modes go from idle to the done state and then
// to the output register. Digit modes (palindrome, reverse, sum) run one
// 32-step pass of the shared divider by ten per decimal digit. Prime mode
// runs one pass of the shared divider per trial divisor d with d*d <= n.
// One item at a time: in_i.ready is high only in idle. The output register
// decouples the sink; a stalled result holds while the next item is taken.
// Reset (async, active low) clears the sequencer and output valid.
module integer_property_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  ipu_in_if.sink         in_i,
  ipu_out_if.source      out_o
);
  localparam int NW = ipu_pkg::NUMBER_WIDTH;
  localparam int VW = ipu_pkg::VALUE_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRIME = 3'd1; // check d*d against n, launch divide
  localparam logic [2:0] ST_PWAIT = 3'd2;
  localparam logic [2:0] ST_DIGIT = 3'd3; // peel next digit or finish
  localparam logic [2:0] ST_DWAIT = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5; // wait for output register

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // input decode
  logic [NW-1:0]       raw, in_pos;
  logic                in_neg, in_zero, in_acc;
  ipu_pkg::mode_e      in_mode;

  assign raw     = in_i.number[NW-1:0];
  assign in_neg  = raw[NW-1];
  assign in_zero = (raw == '0);
  assign in_pos  = in_neg ? '0 : raw;
  assign in_mode = ipu_pkg::mode_e'(in_i.mode);
  assign in_acc  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  // working registers
  ipu_pkg::mode_e              mode_q;
  logic [NW-1:0]               pos_q, v_q, d_q;
  logic [NW:0]                 sq_q;
  logic                        neg_q;
  logic [VW-1:0]               r_q;
  logic [ipu_pkg::SUM_W-1:0]   s_q;
  logic                        ans_q, bad_q;
  logic [1:0]                  cls_q;

  // output register
  logic                        o_ans_q, o_bad_q;
  logic [1:0]                  o_cls_q;
  logic [VW-1:0]               o_val_q;

  ipu_pkg::div_req_t           div_req;
  ipu_pkg::div_rsp_t           div_rsp;

  logic                        sq_gt, out_free, rem_zero;
  logic [ipu_pkg::DIGIT_W-1:0] digit;
  logic [VW-1:0]               r_next;

  assign sq_gt    = sq_q > {1'b0, pos_q};
  assign out_free = !out_valid_q || out_o.ready;
  assign rem_zero = (div_rsp.remainder == '0);
  assign digit    = div_rsp.remainder[ipu_pkg::DIGIT_W-1:0];
  // r*10 + digit as shift-add
  assign r_next   = (r_q << 3) + (r_q << 1) + VW'(digit);

  // one divider shared by trial division and digit extraction
  always_comb begin
    div_req.start    = ((state_q == ST_PRIME) && !sq_gt) ||
                       ((state_q == ST_DIGIT) && (v_q != '0));
    div_req.dividend = (state_q == ST_PRIME) ? pos_q : v_q;
    div_req.divisor  = (state_q == ST_PRIME) ? d_q : NW'(ipu_pkg::DEC_BASE);
  end

  ipu_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_mode) inside
            ipu_pkg::MODE_PRIME: begin
              state_d = (in_pos < NW'(ipu_pkg::FIRST_DIVISOR)) ? ST_DONE : ST_PRIME;
            end
            ipu_pkg::MODE_PAL, ipu_pkg::MODE_REV, ipu_pkg::MODE_SUM: begin
              state_d = ST_DIGIT;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_PRIME: begin
        state_d = sq_gt ? ST_DONE : ST_PWAIT;
      end
      ST_PWAIT: begin
        if (div_rsp.done) begin
          state_d = rem_zero ? ST_DONE : ST_PRIME;
        end
      end
      ST_DIGIT: begin
        state_d = (v_q == '0) ? ST_DONE : ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_rsp.done) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= in_mode;
      pos_q  <= in_pos;
      neg_q  <= in_neg;
      v_q    <= in_pos;
      r_q    <= '0;
      s_q    <= '0;
      d_q    <= NW'(ipu_pkg::FIRST_DIVISOR);
      sq_q   <= (NW+1)'(ipu_pkg::FIRST_DIVISOR * ipu_pkg::FIRST_DIVISOR);
      ans_q  <= (in_mode == ipu_pkg::MODE_PARITY) && !raw[0];
      bad_q  <= (in_i.mode > ipu_pkg::MODE_SUM);
      if (in_mode == ipu_pkg::MODE_SIGN) begin
        cls_q <= in_zero ? ipu_pkg::SIGN_ZERO :
                 (in_neg ? ipu_pkg::SIGN_NEG : ipu_pkg::SIGN_POS);
      end else begin
        cls_q <= ipu_pkg::SIGN_POS;
      end
    end
    if ((state_q == ST_PRIME) && sq_gt) begin
      ans_q <= 1'b1; // no divisor up to sqrt(n)
    end
    if ((state_q == ST_PWAIT) && div_rsp.done && !rem_zero) begin
      d_q  <= d_q + 1'b1;
      sq_q <= sq_q + {d_q, 1'b1}; // (d+1)^2 = d^2 + 2d + 1
    end
    if ((state_q == ST_DWAIT) && div_rsp.done) begin
      v_q <= div_rsp.quotient;
      r_q <= r_next;
      s_q <= s_q + ipu_pkg::SUM_W'(digit);
    end
    if ((state_q == ST_DIGIT) && (v_q == '0) && (mode_q == ipu_pkg::MODE_PAL)) begin
      ans_q <= !neg_q && (r_q == VW'(pos_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      o_ans_q <= ans_q;
      o_cls_q <= cls_q;
      o_bad_q <= bad_q;
      if (mode_q == ipu_pkg::MODE_REV) begin
        o_val_q <= r_q;
      end else if (mode_q == ipu_pkg::MODE_SUM) begin
        o_val_q <= VW'(s_q);
      end else begin
        o_val_q <= '0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.answer_bit = o_ans_q;
  assign out_o.sign_class = o_cls_q;
  assign out_o.value_out  = o_val_q;
  assign out_o.bad_mode   = o_bad_q;

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while idle");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_PWAIT) || (state_q == ST_DWAIT))
    else $error("divider result outside a wait state");

  a_trial_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PWAIT) |-> (d_q >= NW'(ipu_pkg::FIRST_DIVISOR)))
    else $error("trial divisor below two");

  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.bad_mode) |->
      (!out_o.answer_bit && (out_o.sign_class == ipu_pkg::SIGN_POS) &&
       (out_o.value_out == '0)))
    else $error("invalid mode with nonzero result fields");

endmodule

>>> tb/property_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts one result per accepted input beat and
// compares each accepted output beat with the oldest prediction.
module property_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  ipu_in_if     in_ch_i,
  ipu_out_if    out_ch_i,
  output int    fail_count_o,
  output int    pending_o
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                        answer;
    logic [1:0]                  sign;
    logic [ipu_pkg::VALUE_W-1:0] value;
    logic                        bad;
  } property_t;

  property_t expected_q[$];

  function automatic logic [63:0] reverse_digits(input logic [63:0] mag);
    logic [63:0] acc;
    logic [63:0] rest;
    acc  = '0;
    rest = mag;
    while (rest > 0) begin
      acc  = acc * ipu_pkg::DEC_BASE + rest % ipu_pkg::DEC_BASE;
      rest = rest / ipu_pkg::DEC_BASE;
    end
    return acc;
  endfunction

  function automatic property_t predict_properties(
    input logic [ipu_pkg::NUM_IN_W-1:0] number,
    input logic [ipu_pkg::MODE_W-1:0]   mode
  );
    property_t                        res;
    logic [ipu_pkg::NUMBER_WIDTH-1:0] raw;
    logic                             neg;
    logic                             zero;
    logic [63:0]                      pos;
    logic [63:0]                      div;
    logic [63:0]                      rest;
    logic [63:0]                      acc;
    res  = '0;
    raw  = number[ipu_pkg::NUMBER_WIDTH-1:0];
    neg  = raw[ipu_pkg::NUMBER_WIDTH-1];
    zero = (raw == '0);
    pos  = '0;
    if (!neg) pos = 64'(raw);
    case (mode)
      ipu_pkg::MODE_PARITY: res.answer = ~raw[0];
      ipu_pkg::MODE_PRIME: begin
        // trial division up to sqrt, first divisor ends the search
        res.answer = (pos >= 64'(ipu_pkg::FIRST_DIVISOR));
        div = 64'(ipu_pkg::FIRST_DIVISOR);
        while (res.answer && div * div <= pos) begin
          if (pos % div == 0) res.answer = 1'b0;
          div++;
        end
      end
      ipu_pkg::MODE_PAL:  res.answer = zero || (!neg && reverse_digits(pos) == pos);
      ipu_pkg::MODE_SIGN: res.sign = zero ? ipu_pkg::SIGN_ZERO :
                                     (neg ? ipu_pkg::SIGN_NEG : ipu_pkg::SIGN_POS);
      ipu_pkg::MODE_REV:  res.value = ipu_pkg::VALUE_W'(reverse_digits(pos));
      ipu_pkg::MODE_SUM: begin
        acc  = '0;
        rest = pos;
        while (rest > 0) begin
          acc  = acc + rest % ipu_pkg::DEC_BASE;
          rest = rest / ipu_pkg::DEC_BASE;
        end
        res.value = ipu_pkg::VALUE_W'(acc);
      end
      default:            res.bad = 1'b1;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    property_t want;
    property_t got;
    if (!rst_ni) begin
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_ch_i.valid && in_ch_i.ready)
        expected_q.push_back(predict_properties(in_ch_i.number, in_ch_i.mode));
      if (out_ch_i.valid && out_ch_i.ready) begin
        got = '{out_ch_i.answer_bit, out_ch_i.sign_class, out_ch_i.value_out,
                out_ch_i.bad_mode};
        if (expected_q.size() == 0) begin
          if (fail_count_o < REPORT_LIMIT)
            $display("[%0t] result beat with nothing expected: ans=%0b sign=%0d val=%0d bad=%0b",
                     $realtime, got.answer, got.sign, got.value, got.bad);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.answer !== want.answer || got.sign !== want.sign ||
              got.value !== want.value || got.bad !== want.bad) begin
            if (fail_count_o < REPORT_LIMIT)
              $display("[%0t] mismatch: exp ans=%0b sign=%0d val=%0d bad=%0b, got ans=%0b sign=%0d val=%0d bad=%0b",
                       $realtime, want.answer, want.sign, want.value, want.bad,
                       got.answer, got.sign, got.value, got.bad);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict. Checking lives in property_checker.
module testbench;

  localparam int DIRECTED_N     = 25;
  localparam int RANDOM_N       = 600;
  // longest item is the prime 65521: about 256 trial divisions
  localparam int HANG_LIMIT     = 200000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 20;

  // modes outside the package enum, must raise bad_mode
  localparam logic [ipu_pkg::MODE_W-1:0] MODE_BAD_LO = 3'd6;
  localparam logic [ipu_pkg::MODE_W-1:0] MODE_BAD_HI = 3'd7;

  typedef struct {
    logic signed [ipu_pkg::NUM_IN_W-1:0] number;
    logic [ipu_pkg::MODE_W-1:0]          mode;
  } stim_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   burst_left;
  int   quiet_cycles;
  bit   holdoff_go;

  ipu_in_if  in_ch ();
  ipu_out_if out_ch ();

  integer_property_unit u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  property_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_ch_i      (in_ch),
    .out_ch_i     (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one beat and hold it until accepted. Bursts of random length,
  // random gaps between them; a gap of zero keeps valid high throughout.
  // Called and returns at a falling edge.
  task automatic send_beat(input logic signed [ipu_pkg::NUM_IN_W-1:0] number,
                           input logic [ipu_pkg::MODE_W-1:0]          mode);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.number <= number;
    in_ch.mode   <= mode;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Random operand for a given mode. Prime mode keeps magnitudes small
  // (trial division cost grows with sqrt(n)); large values there are
  // negative or even, which end the search at once.
  function automatic logic signed [ipu_pkg::NUM_IN_W-1:0] pick_number(
    input logic [ipu_pkg::MODE_W-1:0] mode
  );
    int unsigned len;
    int unsigned i;
    int unsigned dig [10];
    logic [63:0] pal;
    if (mode == ipu_pkg::MODE_PRIME) begin
      case ($urandom_range(0, 9))
        0:       return $urandom | 32'h8000_0000;
        1:       return $urandom & 32'hFFFF_FFFE;
        2:       return $urandom_range(0, 3);
        default: return $urandom_range(2, 20000);
      endcase
    end
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 200);
      2: return -$signed($urandom_range(1, 1000));
      3: begin
        // mirrored decimal digits, 1 to 9 long
        len = $urandom_range(1, 9);
        pal = '0;
        for (i = 0; i < len; i++) begin
          if (i < (len + 1) / 2) dig[i] = $urandom_range((i == 0) ? 1 : 0, 9);
          else dig[i] = dig[len - 1 - i];
          pal = pal * ipu_pkg::DEC_BASE + dig[i];
        end
        return pal[ipu_pkg::NUM_IN_W-1:0];
      end
      4: return $urandom_range(0, 99999);
      default: return $urandom_range(1000000000, 2147483647);
    endcase
  endfunction

  // Sender: reset, directed beats, then random beats.
  initial begin
    stim_t directed_beats [DIRECTED_N];
    logic [ipu_pkg::MODE_W-1:0] mode;
    int holdoff_at;

    directed_beats = '{
      // parity: negative even, most negative, largest positive (odd)
      '{-32'sd4,          ipu_pkg::MODE_PARITY},
      '{32'sh8000_0000,   ipu_pkg::MODE_PARITY},
      '{32'sd2147483647,  ipu_pkg::MODE_PARITY},
      // prime: zero and one are not prime, negatives never
      '{32'sd0,           ipu_pkg::MODE_PRIME},
      '{32'sd1,           ipu_pkg::MODE_PRIME},
      '{-32'sd7,          ipu_pkg::MODE_PRIME},
      '{32'sd2,           ipu_pkg::MODE_PRIME},
      '{32'sd4,           ipu_pkg::MODE_PRIME},
      '{32'sd65521,       ipu_pkg::MODE_PRIME},
      '{32'sd2147483646,  ipu_pkg::MODE_PRIME},
      // palindrome: zero yes, negative no, ten digits, trailing zero
      '{32'sd0,           ipu_pkg::MODE_PAL},
      '{-32'sd121,        ipu_pkg::MODE_PAL},
      '{32'sd12321,       ipu_pkg::MODE_PAL},
      '{32'sd2147447412,  ipu_pkg::MODE_PAL},
      '{32'sd10,          ipu_pkg::MODE_PAL},
      // sign classes
      '{32'sd5,           ipu_pkg::MODE_SIGN},
      '{-32'sd5,          ipu_pkg::MODE_SIGN},
      '{32'sd0,           ipu_pkg::MODE_SIGN},
      // reversal past 32 bits, trailing zeros, negative gives 0
      '{32'sd2147483647,  ipu_pkg::MODE_REV},
      '{32'sd1000,        ipu_pkg::MODE_REV},
      '{-32'sd15,         ipu_pkg::MODE_REV},
      // digit sum: large sum, negative gives 0
      '{32'sd1999999999,  ipu_pkg::MODE_SUM},
      '{-32'sd9,          ipu_pkg::MODE_SUM},
      // invalid modes
      '{32'sh8000_0000,   MODE_BAD_LO},
      '{32'sd2147483647,  MODE_BAD_HI}
    };

    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.number <= '0;
    in_ch.mode   <= '0;
    burst_left   = 0;
    holdoff_go   = 1'b0;
    holdoff_at   = $urandom_range(100, 400);
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_beats[k])
      send_beat(directed_beats[k].number, directed_beats[k].mode);

    for (int n = 0; n < RANDOM_N; n++) begin
      if (n == holdoff_at) holdoff_go = 1'b1;
      mode = ipu_pkg::MODE_W'($urandom_range(0, 7));
      send_beat(pick_number(mode), mode);
    end
    in_ch.valid <= 1'b0;

    // every beat gives one result: wait for all, then a short drain
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: segments of always-ready, coin-flip and mostly-stalled,
  // plus one long hold-off so the block fills and stalls its input.
  initial begin
    int  seg_left;
    int  style;
    bit  held;
    out_ch.ready <= 1'b0;
    seg_left = 0;
    style    = 0;
    held     = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_go && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end else begin
        if (seg_left == 0) begin
          style    = $urandom_range(0, 2);
          seg_left = $urandom_range(5, 60);
        end
        seg_left--;
        case (style)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: cycles with no beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

>>> files.f
hdl/ipu_pkg.sv
hdl/ipu_if.sv
hdl/ipu_div.sv
hdl/integer_property_unit.sv
tb/property_checker.sv
tb/testbench.sv
